### rtl/core/three_voice_oscillator_mixer_defines.svh
// ----------------------------------------------------------------------------
// Three-voice oscillator mixer - assertion macros
// Shared concurrent assertion wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef THREE_VOICE_OSCILLATOR_MIXER_DEFINES_SVH
`define THREE_VOICE_OSCILLATOR_MIXER_DEFINES_SVH

// Clocked assertion, masked while reset is asserted (active low).
`define TVOM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TVOM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tvom_pkg.sv
// ----------------------------------------------------------------------------
// tvom_pkg
// Types and constants of the three-voice oscillator mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvom_pkg;

    // Input beat: one sample tick
    typedef struct packed {
        logic [2:0] voice_gates;
        logic [2:0] wave_select;
        logic       vibrato_on;
        logic       last_of_buffer;
    } t_in_item;

    // Output beat: one mixed sample
    typedef struct packed {
        logic signed [17:0] mixed_sample;
        logic               end_of_buffer;
    } t_out_item;

    // Configuration register indexes
    localparam logic [2:0] CFG_VOICE_ONE_STEP    = 3'd0;
    localparam logic [2:0] CFG_VOICE_TWO_STEP    = 3'd1;
    localparam logic [2:0] CFG_VOICE_THREE_STEP  = 3'd2;
    localparam logic [2:0] CFG_VOICE_ONE_LEVEL   = 3'd3;
    localparam logic [2:0] CFG_VOICE_TWO_LEVEL   = 3'd4;
    localparam logic [2:0] CFG_VOICE_THREE_LEVEL = 3'd5;
    localparam logic [2:0] CFG_VIBRATO_DEPTH     = 3'd6;

    // Quarter-wave sine polynomial coefficients, Q15
    localparam logic [15:0] SIN_A = 16'd51437;
    localparam logic [14:0] SIN_B = 15'd20953;
    localparam logic [11:0] SIN_C = 12'd2285;

    // Sine pipeline depth in enabled cycles
    localparam int SINE_LAT = 4;

    // Result queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;

endpackage

`default_nettype wire

### rtl/core/tvom_sine_pipe.sv
// ----------------------------------------------------------------------------
// tvom_sine_pipe
// Four-stage Q1.15 sine of a 32-bit phase, one multiply per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvom_sine_pipe import tvom_pkg::*; #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [31:0]        i_phase,
    output logic signed [15:0]      o_sine
);

    // stage 0: quadrant fold and z^2
    logic [15:0] t_idx;
    logic [1:0]  quad;
    logic [14:0] z;
    logic [29:0] zz;

    assign t_idx = {i_phase[31 -: TABLE_BITS], {(16 - TABLE_BITS){1'b0}}};
    assign quad  = t_idx[15:14];
    assign z     = quad[0] ? (15'h4000 - {1'b0, t_idx[13:0]}) : {1'b0, t_idx[13:0]};
    assign zz    = z * z;

    logic        r_s1_neg, r_s2_neg, r_s3_neg;
    logic [14:0] r_s1_z, r_s2_z, r_s3_z;
    logic [14:0] r_s1_z2, r_s2_z2;
    logic [14:0] r_s2_r;
    logic [15:0] r_s3_r;
    logic signed [15:0] r_sine;

    // stage 1: B - C*z2
    logic [26:0] cz;
    assign cz = 27'(SIN_C) * 27'(r_s1_z2);

    // stage 2: A - r*z2
    logic [29:0] rz2;
    assign rz2 = r_s2_r * r_s2_z2;

    // stage 3: r*z, saturate, sign
    logic [30:0] rz;
    logic [16:0] q;
    logic [14:0] mag;
    assign rz  = r_s3_r * r_s3_z;
    assign q   = rz[30:14];
    assign mag = (q > 17'd32767) ? 15'h7FFF : q[14:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_neg <= quad[1];
            r_s1_z   <= z;
            r_s1_z2  <= zz[28:14];

            r_s2_neg <= r_s1_neg;
            r_s2_z   <= r_s1_z;
            r_s2_z2  <= r_s1_z2;
            r_s2_r   <= SIN_B - {3'b000, cz[25:14]};

            r_s3_neg <= r_s2_neg;
            r_s3_z   <= r_s2_z;
            r_s3_r   <= SIN_A - {1'b0, rz2[28:14]};

            r_sine   <= r_s3_neg ? $signed(16'd0 - {1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign o_sine = r_sine;

endmodule

`default_nettype wire

### rtl/core/three_voice_oscillator_mixer.sv
// Result path: voice sine pipes, level scaling register, then the result queue.
// Throughput: one input beat per cycle; a queue of 8 results keeps input
//   flowing while the output side stalls, and input ready drops only once
//   8 results are outstanding.
// Reset: synchronous, active low. After reset the LFO sine lookahead primes
//   with input ready low; config writes are taken once reset is released.
// ----------------------------------------------------------------------------
// three_voice_oscillator_mixer
// Three DDS voices (sine or square) with shared vibrato, mixed to one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_voice_oscillator_mixer import tvom_pkg::*; #(
    parameter int LFO_STEP        = 973845,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample tick channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    // mixed sample channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data
);

    localparam int PRIME_W = $clog2(SINE_LAT + 1);
    localparam int PEND_W  = $clog2(OFIFO_DEPTH + 1);

    // round(mag * a / 32768), halves away from zero (sign handled outside)
    function automatic logic [23:0] scale_mag(input logic [23:0] mag,
                                              input logic [14:0] a);
        logic [38:0] p;
        begin
            p = mag * a + 39'd16384;
            return p[38:15];
        end
    endfunction

    // magnitude of a Q1.15 sine in [-32767, 32767]
    function automatic logic [14:0] abs_q15(input logic signed [15:0] s);
        logic [15:0] neg;
        begin
            neg = 16'd0 - s;
            return s[15] ? neg[14:0] : s[14:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Config registers. Writes are registered; index 7 is dropped.
    // ------------------------------------------------------------------
    logic [30:0] r_step  [3];
    logic [14:0] r_level [3];
    logic [23:0] r_depth;
    logic        cfg_wr;

    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step[0]  <= 31'd25480551;
            r_step[1]  <= 31'd32103176;
            r_step[2]  <= 31'd38177487;
            r_level[0] <= 15'd8192;
            r_level[1] <= 15'd8192;
            r_level[2] <= 15'd8192;
            r_depth    <= 24'd611931;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_VOICE_ONE_STEP:    r_step[0]  <= i_cfg_data;
                CFG_VOICE_TWO_STEP:    r_step[1]  <= i_cfg_data;
                CFG_VOICE_THREE_STEP:  r_step[2]  <= i_cfg_data;
                CFG_VOICE_ONE_LEVEL:   r_level[0] <= i_cfg_data[14:0];
                CFG_VOICE_TWO_LEVEL:   r_level[1] <= i_cfg_data[14:0];
                CFG_VOICE_THREE_LEVEL: r_level[2] <= i_cfg_data[14:0];
                CFG_VIBRATO_DEPTH:     r_depth    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake bookkeeping. r_pend counts beats accepted but not yet
    // delivered, so the result queue can never overflow.
    // ------------------------------------------------------------------
    logic               in_acc;
    logic               out_acc;
    logic [PRIME_W-1:0] r_prime_cnt;
    logic               primed;
    logic [PEND_W-1:0]  r_pend;

    assign primed     = (r_prime_cnt == PRIME_W'(SINE_LAT));
    assign o_in_ready = primed && (r_pend < PEND_W'(OFIFO_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PEND_W'(in_acc) - PEND_W'(out_acc);
        end
    end

    // ------------------------------------------------------------------
    // LFO lookahead. The LFO phase sequence is fixed, so its sine pipe runs
    // SINE_LAT ticks ahead and steps once per accepted beat. Its output is
    // always sine(lfo_phase) for the tick about to be accepted.
    // ------------------------------------------------------------------
    logic        lfo_adv;
    logic [31:0] r_lfo_head;
    logic signed [15:0] lfo_sine;

    assign lfo_adv = in_acc || !primed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_cnt <= '0;
            r_lfo_head  <= '0;
        end else begin
            if (!primed) begin
                r_prime_cnt <= r_prime_cnt + PRIME_W'(1);
            end
            if (lfo_adv) begin
                r_lfo_head <= r_lfo_head + 32'(LFO_STEP);
            end
        end
    end

    tvom_sine_pipe #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_lfo_sine (
        .i_clk   (i_clk),
        .i_en    (lfo_adv),
        .i_phase (r_lfo_head),
        .o_sine  (lfo_sine)
    );

    // ------------------------------------------------------------------
    // Vibrato deviation and phase accumulators. The phases advance on
    // every accepted beat, gated or not; the deviation wraps mod 2^32.
    // ------------------------------------------------------------------
    logic [23:0] dev_mag;
    logic [31:0] dev;
    logic [31:0] r_phase [3];

    assign dev_mag = scale_mag(r_depth, abs_q15(lfo_sine));

    always_comb begin
        if (!i_in_data.vibrato_on) begin
            dev = '0;
        end else if (lfo_sine[15]) begin
            dev = 32'd0 - {8'd0, dev_mag};
        end else begin
            dev = {8'd0, dev_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 3; n++) begin
                r_phase[n] <= '0;
            end
        end else if (in_acc) begin
            for (int n = 0; n < 3; n++) begin
                r_phase[n] <= r_phase[n] + {1'b0, r_step[n]} + dev;
            end
        end
    end

    // ------------------------------------------------------------------
    // Voice sine pipes see the pre-tick phases in the accept cycle and
    // run freely; a side-band shift line carries the tick's control bits.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [2:0] gates;
        logic [2:0] waves;
        logic [2:0] square_hi;
        logic       last;
    } t_side;

    logic               r_vld  [SINE_LAT];
    t_side              r_side [SINE_LAT];
    logic signed [15:0] voice_sine [3];
    t_side              side_in;

    assign side_in = '{gates:     i_in_data.voice_gates,
                       waves:     i_in_data.wave_select,
                       square_hi: {r_phase[2][31], r_phase[1][31], r_phase[0][31]},
                       last:      i_in_data.last_of_buffer};

    for (genvar g = 0; g < 3; g++) begin : g_voice
        tvom_sine_pipe #(
            .TABLE_BITS (SINE_TABLE_BITS)
        ) u_sine (
            .i_clk   (i_clk),
            .i_en    (1'b1),
            .i_phase (r_phase[g]),
            .o_sine  (voice_sine[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SINE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= in_acc;
            for (int k = 1; k < SINE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= side_in;
        for (int k = 1; k < SINE_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Level scaling per voice, then the three-way sum into the queue.
    // ------------------------------------------------------------------
    t_side              tail;
    logic signed [15:0] n_voice [3];
    logic signed [15:0] r_voice [3];
    logic               r_scl_vld;
    logic               r_scl_last;

    assign tail = r_side[SINE_LAT-1];

    always_comb begin
        logic [23:0] m;
        logic [15:0] lvl;
        for (int n = 0; n < 3; n++) begin
            m   = scale_mag({9'd0, r_level[n]}, abs_q15(voice_sine[n]));
            lvl = {1'b0, r_level[n]};
            if (!tail.gates[n]) begin
                n_voice[n] = '0;
            end else if (tail.waves[n]) begin
                n_voice[n] = tail.square_hi[n] ? $signed(lvl) : $signed(16'd0 - lvl);
            end else begin
                n_voice[n] = voice_sine[n][15] ? $signed(16'd0 - m[15:0])
                                               : $signed(m[15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_vld <= 1'b0;
        end else begin
            r_scl_vld <= r_vld[SINE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_scl_last <= tail.last;
        for (int n = 0; n < 3; n++) begin
            r_voice[n] <= n_voice[n];
        end
    end

    t_out_item mix;
    assign mix.mixed_sample  = 18'(r_voice[0]) + 18'(r_voice[1]) + 18'(r_voice[2]);
    assign mix.end_of_buffer = r_scl_last;

    // ------------------------------------------------------------------
    // Result queue. Pointers carry one extra bit for full/empty.
    // ------------------------------------------------------------------
    t_out_item           r_fifo [OFIFO_DEPTH];
    logic [OFIFO_AW:0]   r_wr_ptr;
    logic [OFIFO_AW:0]   r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (r_scl_vld) begin
                r_wr_ptr <= r_wr_ptr + (OFIFO_AW+1)'(1);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + (OFIFO_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_scl_vld) begin
            r_fifo[r_wr_ptr[OFIFO_AW-1:0]] <= mix;
        end
    end

    assign o_out_valid = (r_wr_ptr != r_rd_ptr);
    assign o_out_data  = r_fifo[r_rd_ptr[OFIFO_AW-1:0]];

endmodule

`default_nettype wire

### rtl/core/tvom_checker.sv
// ----------------------------------------------------------------------------
// tvom_checker
// Port-level checks of the three-voice oscillator mixer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "three_voice_oscillator_mixer_defines.svh"

module tvom_checker import tvom_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    `TVOM_ASSERT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result beat dropped while stalled")
    `TVOM_ASSERT(a_out_data_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data), "stalled result beat changed")
    `TVOM_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_ready), "reset left a beat or ready pending")
    `TVOM_ASSERT(a_mix_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.mixed_sample <= 98301 && o_out_data.mixed_sample >= -98301), "mixed sample out of range")

endmodule

bind three_voice_oscillator_mixer tvom_checker u_tvom_checker (.*);

`default_nettype wire
